// ===== rtl/qrv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qrv_pkg;

	// field widths
	localparam int QUAT_W  = 16;
	localparam int VEC_W   = 24;

	// intermediate widths
	localparam int PROD1_W = 40;  // quaternion word times vector word
	localparam int T_W     = 41;  // component of q * v
	localparam int PROD2_W = 56;  // component of q * v times quaternion word
	localparam int P_W     = 58;  // component of q * v * conj(q)
	localparam int N_W     = 33;  // squared norm
	localparam int SQ_W    = 31;  // one squared quaternion word
	localparam int D_W     = N_W + 1;          // doubled norm, divisor
	localparam int NUM_W   = P_W + 2;          // 2 * |p| + n
	localparam int QUO_W   = VEC_W;            // quotient bits per lane
	localparam int REM_W   = D_W;              // partial remainder

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd3;

	localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = 16'sd4096;

	localparam logic [VEC_W-1:0] VEC_MAX = 24'h7FFFFF;
	localparam logic [VEC_W-1:0] VEC_MIN = 24'h800000;

	// rotation quaternion as held by the register file
	typedef struct packed {
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
		logic signed [QUAT_W-1:0] w;
	} quat_t;

	// exact numerator of each rotated component
	typedef struct packed {
		logic signed [P_W-1:0] x;
		logic signed [P_W-1:0] y;
		logic signed [P_W-1:0] z;
	} pvec_t;

	// state that travels down the divide stages
	typedef struct packed {
		logic             vld;
		logic             neg;
		logic             ovf;
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] low;
	} div_state_t;

endpackage

`default_nettype wire

// ===== rtl/qrv_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qrv_norm (
	input  wire logic                    clk,
	input  wire qrv_pkg::quat_t          quat,
	output logic [qrv_pkg::N_W-1:0]      norm
);

	logic [qrv_pkg::SQ_W-1:0] sq_x_q;
	logic [qrv_pkg::SQ_W-1:0] sq_y_q;
	logic [qrv_pkg::SQ_W-1:0] sq_z_q;
	logic [qrv_pkg::SQ_W-1:0] sq_w_q;
	logic [qrv_pkg::N_W-1:0]  norm_q;

	// square each word
	always_ff @(posedge clk) begin
		sq_x_q <= qrv_pkg::SQ_W'(quat.x) * qrv_pkg::SQ_W'(quat.x);
		sq_y_q <= qrv_pkg::SQ_W'(quat.y) * qrv_pkg::SQ_W'(quat.y);
		sq_z_q <= qrv_pkg::SQ_W'(quat.z) * qrv_pkg::SQ_W'(quat.z);
		sq_w_q <= qrv_pkg::SQ_W'(quat.w) * qrv_pkg::SQ_W'(quat.w);
	end

	// sum the squares
	always_ff @(posedge clk) begin
		norm_q <= qrv_pkg::N_W'(sq_x_q) + qrv_pkg::N_W'(sq_y_q)
			+ qrv_pkg::N_W'(sq_z_q) + qrv_pkg::N_W'(sq_w_q);
	end

	assign norm = norm_q;

endmodule

`default_nettype wire

// ===== rtl/qrv_product.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qrv_product (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_vld,
	input  wire qrv_pkg::quat_t                quat,
	input  wire logic signed [qrv_pkg::VEC_W-1:0] vx,
	input  wire logic signed [qrv_pkg::VEC_W-1:0] vy,
	input  wire logic signed [qrv_pkg::VEC_W-1:0] vz,
	output logic                               out_vld,
	output qrv_pkg::pvec_t                     prod
);

	localparam int A = qrv_pkg::PROD1_W;
	localparam int T = qrv_pkg::T_W;
	localparam int B = qrv_pkg::PROD2_W;
	localparam int P = qrv_pkg::P_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [A-1:0] wx_s1, yz_s1, zy_s1;
	logic signed [A-1:0] wy_s1, zx_s1, xz_s1;
	logic signed [A-1:0] wz_s1, xy_s1, yx_s1;
	logic signed [A-1:0] xx_s1, yy_s1, zz_s1;

	logic signed [T-1:0] tx_s2, ty_s2, tz_s2, tw_s2;

	logic signed [B-1:0] ax_s3, bx_s3, cx_s3, dx_s3;
	logic signed [B-1:0] ay_s3, by_s3, cy_s3, dy_s3;
	logic signed [B-1:0] az_s3, bz_s3, cz_s3, dz_s3;

	logic signed [P-1:0] px_s4, py_s4, pz_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: quaternion words times vector words
	always_ff @(posedge clk) begin
		wx_s1 <= A'(quat.w) * A'(vx);
		yz_s1 <= A'(quat.y) * A'(vz);
		zy_s1 <= A'(quat.z) * A'(vy);
		wy_s1 <= A'(quat.w) * A'(vy);
		zx_s1 <= A'(quat.z) * A'(vx);
		xz_s1 <= A'(quat.x) * A'(vz);
		wz_s1 <= A'(quat.w) * A'(vz);
		xy_s1 <= A'(quat.x) * A'(vy);
		yx_s1 <= A'(quat.y) * A'(vx);
		xx_s1 <= A'(quat.x) * A'(vx);
		yy_s1 <= A'(quat.y) * A'(vy);
		zz_s1 <= A'(quat.z) * A'(vz);
	end

	// stage 2: t = q * v
	always_ff @(posedge clk) begin
		tx_s2 <= T'(wx_s1) + T'(yz_s1) - T'(zy_s1);
		ty_s2 <= T'(wy_s1) + T'(zx_s1) - T'(xz_s1);
		tz_s2 <= T'(wz_s1) + T'(xy_s1) - T'(yx_s1);
		tw_s2 <= -T'(xx_s1) - T'(yy_s1) - T'(zz_s1);
	end

	// stage 3: t times the words of conj(q)
	always_ff @(posedge clk) begin
		ax_s3 <= B'(tw_s2) * B'(quat.x);
		bx_s3 <= B'(tx_s2) * B'(quat.w);
		cx_s3 <= B'(ty_s2) * B'(quat.z);
		dx_s3 <= B'(tz_s2) * B'(quat.y);
		ay_s3 <= B'(tw_s2) * B'(quat.y);
		by_s3 <= B'(ty_s2) * B'(quat.w);
		cy_s3 <= B'(tz_s2) * B'(quat.x);
		dy_s3 <= B'(tx_s2) * B'(quat.z);
		az_s3 <= B'(tw_s2) * B'(quat.z);
		bz_s3 <= B'(tz_s2) * B'(quat.w);
		cz_s3 <= B'(tx_s2) * B'(quat.y);
		dz_s3 <= B'(ty_s2) * B'(quat.x);
	end

	// stage 4: vector part of t * conj(q)
	always_ff @(posedge clk) begin
		px_s4 <= -P'(ax_s3) + P'(bx_s3) - P'(cx_s3) + P'(dx_s3);
		py_s4 <= -P'(ay_s3) + P'(by_s3) - P'(cy_s3) + P'(dy_s3);
		pz_s4 <= -P'(az_s3) + P'(bz_s3) - P'(cz_s3) + P'(dz_s3);
	end

	assign out_vld = vld_s4;
	assign prod.x  = px_s4;
	assign prod.y  = py_s4;
	assign prod.z  = pz_s4;

endmodule

`default_nettype wire

// ===== rtl/qrv_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qrv_div_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [qrv_pkg::D_W-1:0]     dvsr,
	input  wire qrv_pkg::div_state_t         st_in,
	output qrv_pkg::div_state_t              st_out
);

	localparam int R = qrv_pkg::REM_W;
	localparam int Q = qrv_pkg::QUO_W;

	logic [R:0]   rem_sh;
	logic         ge;
	logic [R-1:0] rem_nxt;
	logic         vld_s1;
	qrv_pkg::div_state_t st_s1;

	// bring down the next numerator bit and try the subtract
	always_comb begin
		rem_sh  = {st_in.rem, st_in.low[Q-1]};
		ge      = rem_sh >= {1'b0, dvsr};
		rem_nxt = ge ? R'(rem_sh - {1'b0, dvsr}) : R'(rem_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= st_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		st_s1.vld <= 1'b0;
		st_s1.neg <= st_in.neg;
		st_s1.ovf <= st_in.ovf;
		st_s1.rem <= rem_nxt;
		st_s1.quo <= {st_in.quo[Q-2:0], ge};
		st_s1.low <= {st_in.low[Q-2:0], 1'b0};
	end

	always_comb begin
		st_out     = st_s1;
		st_out.vld = vld_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/qrv_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qrv_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_vld,
	input  wire logic signed [qrv_pkg::P_W-1:0]    num,
	input  wire logic [qrv_pkg::N_W-1:0]           norm,
	output logic                                   out_vld,
	output logic [qrv_pkg::VEC_W-1:0]              res,
	output logic                                   clip
);

	localparam int P  = qrv_pkg::P_W;
	localparam int NW = qrv_pkg::NUM_W;
	localparam int D  = qrv_pkg::D_W;
	localparam int Q  = qrv_pkg::QUO_W;
	localparam int R  = qrv_pkg::REM_W;

	logic [D-1:0]  dvsr;
	logic [P-1:0]  mag;
	logic          vld_s1, vld_s2;
	logic          neg_s1;
	logic [NW-1:0] num_s1;
	qrv_pkg::div_state_t st_s2;
	qrv_pkg::div_state_t chain [Q+1];

	logic over_pos, over_neg;

	// divisor is twice the norm so the rounding half stays integer
	assign dvsr = {norm, 1'b0};
	assign mag  = num[P-1] ? P'(-num) : P'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: take magnitude and add half the divisor
	always_ff @(posedge clk) begin
		neg_s1 <= num[P-1];
		num_s1 <= {1'b0, mag, 1'b0} + NW'(norm);
	end

	// stage 2: flag quotients that do not fit, load the remainder
	always_ff @(posedge clk) begin
		st_s2.vld <= 1'b0;
		st_s2.neg <= neg_s1;
		st_s2.ovf <= num_s1[NW-1:Q] >= (NW-Q)'(dvsr);
		st_s2.rem <= num_s1[Q+R-1:Q];
		st_s2.quo <= '0;
		st_s2.low <= num_s1[Q-1:0];
	end

	always_comb begin
		chain[0]     = st_s2;
		chain[0].vld = vld_s2;
	end

	// one quotient bit per stage
	for (genvar i = 0; i < Q; i++) begin : g_step
		qrv_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.dvsr   (dvsr),
			.st_in  (chain[i]),
			.st_out (chain[i+1])
		);
	end

	// saturate and restore the sign
	always_comb begin
		over_pos = chain[Q].ovf || chain[Q].quo[Q-1];
		over_neg = chain[Q].ovf || (chain[Q].quo > {1'b1, {(Q-1){1'b0}}});
		if (chain[Q].neg) begin
			clip = over_neg;
			res  = over_neg ? qrv_pkg::VEC_MIN : Q'(-chain[Q].quo);
		end else begin
			clip = over_pos;
			res  = over_pos ? qrv_pkg::VEC_MAX : chain[Q].quo;
		end
	end

	assign out_vld = chain[Q].vld;

endmodule

`default_nettype wire

// ===== rtl/quaternion_rotate_vector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rotates a signed Q12.12 vector by the quaternion held in the four Q4.12
// registers, giving q * v * conj(q) / |q|^2 rounded half away from zero and
// saturated to 24 bits. One vector is taken every cycle while busy is low;
// each result passes the stages of the two Hamilton products, the divide
// setup stages, the divide by |q|^2 (one quotient bit per pipeline stage
// in each of three lanes) and one output register before it appears on
// done. The receiver cannot stall the pipeline; every done pulse must be
// taken. busy is high only in the cycle that follows reset. Write the
// quaternion only when no vector is in flight; the squared norm settles
// in the squaring and summing registers after the write. A quaternion of
// all zeros returns a zero vector with zero_norm set.
module quaternion_rotate_vector_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [qrv_pkg::VEC_W-1:0]    vec_x,
	input  wire logic signed [qrv_pkg::VEC_W-1:0]    vec_y,
	input  wire logic signed [qrv_pkg::VEC_W-1:0]    vec_z,
	output logic                                     done,
	output logic signed [qrv_pkg::VEC_W-1:0]         rot_x,
	output logic signed [qrv_pkg::VEC_W-1:0]         rot_y,
	output logic signed [qrv_pkg::VEC_W-1:0]         rot_z,
	output logic                                     zero_norm,
	output logic                                     saturated,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [qrv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [qrv_pkg::QUAT_W-1:0]          cfg_data
);

	qrv_pkg::quat_t quat_q;
	logic           busy_q;
	logic           accept;
	logic [qrv_pkg::N_W-1:0] norm;
	logic           prod_vld;
	qrv_pkg::pvec_t prod;
	logic           vld_x, vld_y, vld_z;
	logic [qrv_pkg::VEC_W-1:0] res_x, res_y, res_z;
	logic           clip_x, clip_y, clip_z;
	logic           is_zero;

	logic                      done_q;
	logic [qrv_pkg::VEC_W-1:0] rot_x_q, rot_y_q, rot_z_q;
	logic                      zero_q, sat_q;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	// hold off requests for the first cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// quaternion registers; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
			quat_q.w <= qrv_pkg::QUAT_W_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qrv_pkg::REG_QUAT_X: quat_q.x <= cfg_data;
				qrv_pkg::REG_QUAT_Y: quat_q.y <= cfg_data;
				qrv_pkg::REG_QUAT_Z: quat_q.z <= cfg_data;
				qrv_pkg::REG_QUAT_W: quat_q.w <= cfg_data;
				default: ;
			endcase
		end
	end

	qrv_norm u_norm (
		.clk  (clk),
		.quat (quat_q),
		.norm (norm)
	);

	qrv_product u_product (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.quat    (quat_q),
		.vx      (vec_x),
		.vy      (vec_y),
		.vz      (vec_z),
		.out_vld (prod_vld),
		.prod    (prod)
	);

	qrv_divider u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (prod_vld),
		.num     (prod.x),
		.norm    (norm),
		.out_vld (vld_x),
		.res     (res_x),
		.clip    (clip_x)
	);

	qrv_divider u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (prod_vld),
		.num     (prod.y),
		.norm    (norm),
		.out_vld (vld_y),
		.res     (res_y),
		.clip    (clip_y)
	);

	qrv_divider u_div_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (prod_vld),
		.num     (prod.z),
		.norm    (norm),
		.out_vld (vld_z),
		.res     (res_z),
		.clip    (clip_z)
	);

	assign is_zero = (norm == '0);

	// output register; the lanes run in lockstep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_x && vld_y && vld_z;
		end
	end

	// force a zero vector for a zero quaternion
	always_ff @(posedge clk) begin
		rot_x_q <= is_zero ? '0 : res_x;
		rot_y_q <= is_zero ? '0 : res_y;
		rot_z_q <= is_zero ? '0 : res_z;
		zero_q  <= is_zero;
		sat_q   <= !is_zero && (clip_x || clip_y || clip_z);
	end

	assign done      = done_q;
	assign rot_x     = rot_x_q;
	assign rot_y     = rot_y_q;
	assign rot_z     = rot_z_q;
	assign zero_norm = zero_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire
